// ===== hw/rtl/mavgw_pkg.sv =====
// Shared constants for the moving average filter with warm-up.
`default_nettype none
package mavgw_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W      = 24;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = $clog2(SUM_W + 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ENABLE        = 2'd0;
  localparam cfg_idx_t REG_WINDOW_SIZE   = 2'd1;
  localparam cfg_idx_t REG_RECORD_LENGTH = 2'd2;

endpackage
`default_nettype wire

// ===== hw/rtl/moving_average_warmup.sv =====
// Moving average filter with warm-up over a 256-entry sample ring.
//
// One sample beat in, one value beat out. While averaging, a sample is accepted
// and the oldest sample read from the ring, then the running sum and count are
// updated, 24 steps of the restoring divider run (one quotient bit per cycle)
// and the output register is loaded once free. A sample that passes through
// skips the sum and divider. in_stall is high while a sample is in work; a
// finished value waits in the output register without blocking the next
// sample. The ring has no reset; entries are written before they are read.
`default_nettype none
module moving_average_warmup
  import mavgw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  in_first,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SAMPLE_W-1:0]        out_value,
  input  wire logic                  cfg_wr_en,
  input  wire cfg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_DIV, S_DONE} state_t;

  state_t              state_r, state_nxt;
  logic                enable_r, enable_nxt;
  logic [CNT_W-1:0]    window_r, window_nxt;
  logic [15:0]         record_r, record_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                drop_r, drop_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SAMPLE_W-1:0] res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;

  logic [SAMPLE_W-1:0] ring [WINDOW_MAX];
  logic [SAMPLE_W-1:0] ring_rd_r;

  logic                in_beat;
  logic                active;
  logic [SUM_W-1:0]    sum_eff;
  logic [CNT_W-1:0]    cnt_eff;
  logic [SLOT_W-1:0]   old_slot;
  logic [SUM_W-1:0]    sum_upd;
  logic [CNT_W-1:0]    cnt_upd;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      trial_diff;

  assign in_stall  = (state_r != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  assign active = enable_r && (window_r >= CNT_W'(2)) &&
                  ({{(16-CNT_W){1'b0}}, window_r} <= record_r) &&
                  (window_r <= CNT_W'(WINDOW_MAX));

  assign sum_eff  = in_first ? '0 : sum_r;
  assign cnt_eff  = in_first ? '0 : cnt_r;
  assign old_slot = slot_r - window_r[SLOT_W-1:0];

  // oldest sample leaves only once the window is full
  assign sum_upd = sum_r
                 - (drop_r ? {{(SUM_W-SAMPLE_W){1'b0}}, ring_rd_r} : '0)
                 + {{(SUM_W-SAMPLE_W){1'b0}}, sample_r};
  assign cnt_upd = (cnt_r < CNT_W'(WINDOW_MAX)) ? cnt_r + CNT_W'(1) : cnt_r;

  assign trial      = {rem_r, quo_r[SUM_W-1]};
  assign trial_diff = trial - {1'b0, div_r};

  // Ring: read of the oldest slot comes before the write of this sample.
  always_ff @(posedge clk) begin
    if (in_beat && active) begin
      ring_rd_r    <= ring[old_slot];
      ring[slot_r] <= in_sample;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    window_nxt    = window_r;
    record_nxt    = record_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    sample_nxt    = sample_r;
    drop_nxt      = drop_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE:        enable_nxt = cfg_data[0];
        REG_WINDOW_SIZE:   window_nxt = cfg_data[CNT_W-1:0];
        REG_RECORD_LENGTH: record_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          sum_nxt    = sum_eff;
          cnt_nxt    = cnt_eff;
          sample_nxt = in_sample;
          res_nxt    = in_sample;
          drop_nxt   = (cnt_eff >= window_r);
          if (active) begin
            slot_nxt  = slot_r + SLOT_W'(1);
            state_nxt = S_UPDATE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_UPDATE: begin
        sum_nxt  = sum_upd;
        cnt_nxt  = cnt_upd;
        quo_nxt  = sum_upd;
        rem_nxt  = '0;
        div_nxt  = (cnt_upd < window_r) ? cnt_upd : window_r;
        if (div_nxt == '0) begin
          div_nxt = CNT_W'(1);
        end
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!trial_diff[CNT_W]) begin
          rem_nxt = trial_diff[CNT_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[CNT_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          // quotient above 16 bits saturates
          res_nxt   = (|quo_nxt[SUM_W-1:SAMPLE_W]) ? '1 : quo_nxt[SAMPLE_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      window_r    <= '0;
      record_r    <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      window_r    <= window_nxt;
      record_r    <= record_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r    <= sample_nxt;
    drop_r      <= drop_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    step_r      <= step_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule
`default_nettype wire
